// ===== src/mpg_pkg.sv =====
// shared types and constants of the prim maze generator
package mpg_pkg;

    localparam int RND_W   = 16;
    localparam int COORD_W = 6;
    localparam int SIDE_W  = 7;
    localparam int LEFT_W  = 11;
    localparam int MIN_SIDE = 5;

    // grid store side and frontier list depth, tied to the port widths
    localparam int MAX_SIDE       = 64;
    localparam int FRONTIER_DEPTH = 1024;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    localparam logic [1:0] CELL_WALL      = 2'd0;
    localparam logic [1:0] CELL_UNVISITED = 2'd1;
    localparam logic [1:0] CELL_OPEN      = 2'd2;
    localparam logic [1:0] CELL_FRONTIER  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic sweep_init;
        logic sweep_en;
        logic div_go;
        logic rd_idx;
        logic rd_last;
        logic move;
        logic dir_clr;
        logic dir_inc;
        logic wall_wr;
        logic cell_wr;
        logic push_wr;
        logic rd_cell;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic div_done;
        logic cnt_zero;
        logic full;
        logic nb_in_range;
        logic nb_open;
        logic nb_unvis;
        logic dir_last;
    } t_dp_sts;

endpackage

// ===== src/mpg_div.sv =====
// iterative restoring remainder unit, one dividend bit per cycle
module mpg_div #(
    parameter int VW = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  logic [mpg_pkg::RND_W-1:0] i_dividend,
    input  logic [VW-1:0]          i_divisor,
    output logic                   o_done,
    output logic [VW-1:0]          o_rem
);
    import mpg_pkg::*;

    localparam int CW = $clog2(RND_W);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [RND_W-1:0] r_dvd;
    logic [VW-1:0] r_rem;
    logic [VW:0]   n_trial;

    // shift in next dividend bit
    assign n_trial = {r_rem, r_dvd[RND_W-1]};

    // control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(RND_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // partial remainder
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            if (n_trial >= {1'b0, i_divisor}) begin
                r_rem <= VW'(n_trial - {1'b0, i_divisor});
            end else begin
                r_rem <= VW'(n_trial);
            end
        end
    end

    assign o_done = r_busy && (r_cnt == CW'(RND_W - 1));
    assign o_rem  = r_rem;

endmodule

// ===== src/mpg_dp.sv =====
// datapath: grid store, frontier list, remainder unit and result registers
module mpg_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mpg_pkg::t_dp_cmd                       i_cmd,
    output mpg_pkg::t_dp_sts                       o_sts,
    input  logic [$clog2(mpg_pkg::MAX_SIDE+1)-1:0] i_side,
    input  logic [1:0]                             i_opcode,
    input  logic [mpg_pkg::RND_W-1:0]              i_random_value,
    input  logic [mpg_pkg::COORD_W-1:0]            i_read_row,
    input  logic [mpg_pkg::COORD_W-1:0]            i_read_col,
    output logic [mpg_pkg::COORD_W-1:0]            o_cell_row,
    output logic [mpg_pkg::COORD_W-1:0]            o_cell_col,
    output logic [mpg_pkg::COORD_W-1:0]            o_wall_row,
    output logic [mpg_pkg::COORD_W-1:0]            o_wall_col,
    output logic [1:0]                             o_cell_state,
    output logic [mpg_pkg::LEFT_W-1:0]             o_frontier_left,
    output logic                                   o_finished
);
    import mpg_pkg::*;

    localparam int CW   = $clog2(MAX_SIDE);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int XW   = CW + 2;
    localparam int AW   = 2 * CW;
    localparam int FW   = $clog2(FRONTIER_DEPTH);
    localparam int NW   = $clog2(FRONTIER_DEPTH + 1);

    // storage
    logic [1:0]    grid_mem [2**AW];
    logic [AW-1:0] fl_mem   [FRONTIER_DEPTH];

    logic [1:0]    r_grid_q;
    logic [AW-1:0] r_fl_q;
    logic          r_grid_valid;
    logic [NW-1:0] r_count;
    logic [AW-1:0] r_sweep;
    logic [1:0]    r_dir;
    logic [CW-1:0] r_x, r_y;
    logic [COORD_W-1:0] r_wall_row, r_wall_col, r_rr, r_rc;
    t_opcode       r_op;
    logic          r_fin, r_rd_ok;
    logic [RND_W-1:0] r_rnd;

    logic [NW-1:0] div_rem;
    logic [FW-1:0] idx;
    logic [XW-1:0] nb_r, nb_c, wl_r, wl_c;
    logic          nb_in_range;
    logic [AW-1:0] nb_addr, wl_addr, g_raddr, g_waddr;
    logic [1:0]    g_wdata;
    logic          g_we, f_we;
    logic [FW-1:0] f_raddr, f_waddr;
    logic [AW-1:0] f_wdata;
    logic [CW-1:0] rd_row_cw, rd_col_cw;

    // start pattern of one grid cell
    function automatic logic [1:0] init_val(input logic [AW-1:0] a,
                                           input logic [SW-1:0] s);
        logic [CW-1:0] r;
        logic [CW-1:0] c;
        logic [1:0]    v;
        r = a[AW-1:CW];
        c = a[CW-1:0];
        v = CELL_WALL;
        if (r[0] && c[0] && ({1'b0, r} < (s - 1'b1)) && ({1'b0, c} < (s - 1'b1))) begin
            v = CELL_UNVISITED;
        end
        if (r == CW'(1) && c == CW'(1)) begin
            v = CELL_OPEN;
        end
        if ((r == CW'(3) && c == CW'(1)) || (r == CW'(1) && c == CW'(3))) begin
            v = CELL_FRONTIER;
        end
        return v;
    endfunction

    // the divider loads its dividend at the accepting edge
    mpg_div #(.VW(NW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (i_random_value),
        .i_divisor  (r_count),
        .o_done     (o_sts.div_done),
        .o_rem      (div_rem)
    );

    assign idx       = div_rem[FW-1:0];
    assign rd_row_cw = CW'(r_rr);
    assign rd_col_cw = CW'(r_rc);

    // neighbour and wall coordinates for the current direction
    always_comb begin
        nb_r = {2'b00, r_x};
        nb_c = {2'b00, r_y};
        wl_r = {2'b00, r_x};
        wl_c = {2'b00, r_y};
        nb_in_range = 1'b0;
        unique case (r_dir)
            2'd0: begin
                nb_r = {2'b00, r_x} + XW'(2);
                wl_r = {2'b00, r_x} + XW'(1);
                nb_in_range = nb_r < XW'(i_side);
            end
            2'd1: begin
                nb_r = {2'b00, r_x} - XW'(2);
                wl_r = {2'b00, r_x} - XW'(1);
                nb_in_range = r_x > CW'(2);
            end
            2'd2: begin
                nb_c = {2'b00, r_y} + XW'(2);
                wl_c = {2'b00, r_y} + XW'(1);
                nb_in_range = nb_c < XW'(i_side);
            end
            default: begin
                nb_c = {2'b00, r_y} - XW'(2);
                wl_c = {2'b00, r_y} - XW'(1);
                nb_in_range = r_y > CW'(2);
            end
        endcase
    end

    assign o_sts.nb_in_range = nb_in_range;

    assign nb_addr = {nb_r[CW-1:0], nb_c[CW-1:0]};
    assign wl_addr = {wl_r[CW-1:0], wl_c[CW-1:0]};

    // grid port selection
    always_comb begin
        g_raddr = i_cmd.rd_cell ? {rd_row_cw, rd_col_cw} : nb_addr;
        g_we    = i_cmd.sweep_en | i_cmd.wall_wr | i_cmd.cell_wr | i_cmd.push_wr;
        g_waddr = nb_addr;
        g_wdata = CELL_FRONTIER;
        if (i_cmd.sweep_en) begin
            g_waddr = r_sweep;
            g_wdata = init_val(r_sweep, i_side);
        end else if (i_cmd.wall_wr) begin
            g_waddr = wl_addr;
            g_wdata = CELL_OPEN;
        end else if (i_cmd.cell_wr) begin
            g_waddr = {r_x, r_y};
            g_wdata = CELL_OPEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            grid_mem[g_waddr] <= g_wdata;
        end
        r_grid_q <= grid_mem[g_raddr];
    end

    // frontier list port selection
    always_comb begin
        f_raddr = i_cmd.rd_idx ? idx : FW'(r_count - 1'b1);
        f_we    = 1'b0;
        f_waddr = FW'(r_count);
        f_wdata = nb_addr;
        if (i_cmd.sweep_en && r_sweep < AW'(2)) begin
            f_we    = 1'b1;
            f_waddr = FW'(r_sweep);
            f_wdata = r_sweep[0] ? {CW'(3), CW'(1)} : {CW'(1), CW'(3)};
        end else if (i_cmd.move) begin
            f_we    = 1'b1;
            f_waddr = idx;
            f_wdata = r_fl_q;
        end else if (i_cmd.push_wr) begin
            f_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            fl_mem[f_waddr] <= f_wdata;
        end
        r_fl_q <= fl_mem[f_raddr];
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_valid <= 1'b0;
            r_count      <= '0;
            r_sweep      <= '0;
            r_dir        <= '0;
        end else begin
            if (i_cmd.sweep_init) begin
                r_grid_valid <= 1'b1;
                r_count      <= NW'(2);
                r_sweep      <= '0;
            end else if (i_cmd.sweep_en) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.move) begin
                r_count <= r_count - 1'b1;
            end else if (i_cmd.push_wr) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.dir_clr) begin
                r_dir <= '0;
            end else if (i_cmd.dir_inc) begin
                r_dir <= r_dir + 1'b1;
            end
        end
    end

    // transaction payload and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= t_opcode'(i_opcode);
            r_rnd      <= i_random_value;
            r_rr       <= i_read_row;
            r_rc       <= i_read_col;
            r_rd_ok    <= (32'(i_read_row) < MAX_SIDE) && (32'(i_read_col) < MAX_SIDE);
            r_fin      <= (t_opcode'(i_opcode) == OP_STEP) && (r_count == '0);
            r_wall_row <= '0;
            r_wall_col <= '0;
        end
        if (i_cmd.rd_last) begin
            r_x <= r_fl_q[AW-1:CW];
            r_y <= r_fl_q[CW-1:0];
        end
        if (i_cmd.wall_wr) begin
            r_wall_row <= COORD_W'(wl_r);
            r_wall_col <= COORD_W'(wl_c);
        end
    end

    assign o_sts.sweep_last = &r_sweep;
    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.full       = (r_count >= NW'(FRONTIER_DEPTH));
    assign o_sts.nb_open    = (r_grid_q == CELL_OPEN);
    assign o_sts.nb_unvis   = (r_grid_q == CELL_UNVISITED);
    assign o_sts.dir_last   = (r_dir == 2'd3);

    // result fields
    always_comb begin
        o_cell_row   = '0;
        o_cell_col   = '0;
        o_cell_state = CELL_WALL;
        if (r_op == OP_STEP && !r_fin) begin
            o_cell_row = COORD_W'(r_x);
            o_cell_col = COORD_W'(r_y);
        end else if (r_op == OP_READ) begin
            o_cell_row = r_rr;
            o_cell_col = r_rc;
            if (r_rd_ok && r_grid_valid) begin
                o_cell_state = r_grid_q;
            end
        end
    end

    assign o_wall_row      = r_wall_row;
    assign o_wall_col      = r_wall_col;
    assign o_frontier_left = LEFT_W'(r_count);
    assign o_finished      = r_fin;

endmodule

// ===== src/mpg_ctrl.sv =====
// controller state machine sequencing each transaction
module mpg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_opcode,
    input  mpg_pkg::t_dp_sts i_sts,
    output mpg_pkg::t_dp_cmd o_cmd,
    output logic             busy,
    output logic             o_result_strobe
);
    import mpg_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CLEAR = 13'b0000000000010,
        S_DIV   = 13'b0000000000100,
        S_RDI   = 13'b0000000001000,
        S_RDL   = 13'b0000000010000,
        S_MOV   = 13'b0000000100000,
        S_CKR   = 13'b0000001000000,
        S_CKE   = 13'b0000010000000,
        S_OPN   = 13'b0000100000000,
        S_PSR   = 13'b0001000000000,
        S_PSE   = 13'b0010000000000,
        S_RDC   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    unique case (t_opcode'(i_opcode))
                        OP_START: begin
                            o_cmd.sweep_init = 1'b1;
                            n_state = S_CLEAR;
                        end
                        OP_STEP: begin
                            if (i_sts.cnt_zero) begin
                                n_state = S_DONE;
                            end else begin
                                o_cmd.div_go = 1'b1;
                                n_state = S_DIV;
                            end
                        end
                        OP_READ: n_state = S_RDC;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.sweep_en = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_RDI;
                end
            end
            S_RDI: begin
                o_cmd.rd_idx = 1'b1;
                n_state = S_RDL;
            end
            S_RDL: begin
                o_cmd.rd_last = 1'b1;
                n_state = S_MOV;
            end
            S_MOV: begin
                o_cmd.move    = 1'b1;
                o_cmd.dir_clr = 1'b1;
                n_state = S_CKR;
            end
            S_CKR: begin
                if (i_sts.nb_in_range) begin
                    n_state = S_CKE;
                end else if (i_sts.dir_last) begin
                    n_state = S_OPN;
                end else begin
                    o_cmd.dir_inc = 1'b1;
                end
            end
            S_CKE: begin
                if (i_sts.nb_open) begin
                    o_cmd.wall_wr = 1'b1;
                    n_state = S_OPN;
                end else if (i_sts.dir_last) begin
                    n_state = S_OPN;
                end else begin
                    o_cmd.dir_inc = 1'b1;
                    n_state = S_CKR;
                end
            end
            S_OPN: begin
                o_cmd.cell_wr = 1'b1;
                o_cmd.dir_clr = 1'b1;
                n_state = S_PSR;
            end
            S_PSR: begin
                if (i_sts.nb_in_range) begin
                    n_state = S_PSE;
                end else if (i_sts.dir_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.dir_inc = 1'b1;
                end
            end
            S_PSE: begin
                o_cmd.push_wr = i_sts.nb_unvis && !i_sts.full;
                if (i_sts.dir_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.dir_inc = 1'b1;
                    n_state = S_PSR;
                end
            end
            S_RDC: begin
                o_cmd.rd_cell = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = (r_state == S_DONE);

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !busy)
        else $error("controller not idle after result");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push_wr |-> !i_sts.full)
        else $error("frontier push while list full");
    a_wall_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wall_wr |=> o_cmd.cell_wr)
        else $error("wall opened without opening the cell");

endmodule

// ===== src/randomized_prim_maze_generator.sv =====
// top level of the randomized prim maze generator
//
// One transaction enters when start is high and busy is low; busy stays high
// until its single result has been shown. The result is on the o_ ports for
// one cycle with o_result_strobe high; the receiver cannot hold it off.
// Opcodes: start a new maze, step (connect one frontier cell), read a cell.
// What a transaction spends its time on, from acceptance to the result:
//   start: the sweep that writes the grid memory one cell a cycle
//          over the whole grid memory
//   step:  the remainder unit, then the one read port of the grid memory
//          (up to eight neighbour reads)
//   step on an empty frontier and no-op go straight to the result; read makes one grid read first
// The next transaction can be taken in the cycle after the result is shown.
// One transaction is in flight at a time.
// Configuration: the side register is written over i_cfg_valid/o_cfg_ready,
// which is always ready; write it only while busy is low.
// After reset the grid reads as wall everywhere, the frontier is empty and
// the side is 31; no clearing pass is run.
module randomized_prim_maze_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic [mpg_pkg::RND_W-1:0]   i_random_value,
    input  logic [mpg_pkg::COORD_W-1:0] i_read_row,
    input  logic [mpg_pkg::COORD_W-1:0] i_read_col,
    output logic                        o_result_strobe,
    output logic [mpg_pkg::COORD_W-1:0] o_cell_row,
    output logic [mpg_pkg::COORD_W-1:0] o_cell_col,
    output logic [mpg_pkg::COORD_W-1:0] o_wall_row,
    output logic [mpg_pkg::COORD_W-1:0] o_wall_col,
    output logic [1:0]                  o_cell_state,
    output logic [mpg_pkg::LEFT_W-1:0]  o_frontier_left,
    output logic                        o_finished,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mpg_pkg::SIDE_W-1:0]  i_cfg_data
);
    import mpg_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);

    logic [SIDE_W-1:0] r_maze_side;
    logic [SW-1:0]     side;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    // side configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maze_side <= SIDE_W'(31);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_maze_side <= i_cfg_data;
        end
    end

    // clamp side to the supported range
    always_comb begin
        if (32'(r_maze_side) < MIN_SIDE) begin
            side = SW'(MIN_SIDE);
        end else if (32'(r_maze_side) > MAX_SIDE) begin
            side = SW'(MAX_SIDE);
        end else begin
            side = SW'(r_maze_side);
        end
    end

    mpg_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_opcode        (i_opcode),
        .i_sts           (sts),
        .o_cmd           (cmd),
        .busy            (busy),
        .o_result_strobe (o_result_strobe)
    );

    mpg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_side          (side),
        .i_opcode        (i_opcode),
        .i_random_value  (i_random_value),
        .i_read_row      (i_read_row),
        .i_read_col      (i_read_col),
        .o_cell_row      (o_cell_row),
        .o_cell_col      (o_cell_col),
        .o_wall_row      (o_wall_row),
        .o_wall_col      (o_wall_col),
        .o_cell_state    (o_cell_state),
        .o_frontier_left (o_frontier_left),
        .o_finished      (o_finished)
    );

endmodule

// ===== tb/sv/randomized_prim_maze_generator_test.sv =====
// self-checking testbench of the randomized prim maze generator
module randomized_prim_maze_generator_test;
    import mpg_pkg::*;

    localparam int GRID_SIDE  = 64;
    localparam int LIST_DEPTH = 1024;

    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic [COORD_W-1:0] wall_row;
        logic [COORD_W-1:0] wall_col;
        logic [1:0]         cell_state;
        logic [LEFT_W-1:0]  frontier_left;
        logic               finished;
    } maze_result_t;

    typedef struct packed {
        t_opcode            op;
        logic [RND_W-1:0]   rnd;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               typed;
        maze_result_t       want;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_opcode;
    logic [RND_W-1:0]     i_random_value;
    logic [COORD_W-1:0]   i_read_row;
    logic [COORD_W-1:0]   i_read_col;
    logic                 o_result_strobe;
    maze_result_t         seen;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [SIDE_W-1:0]    i_cfg_data;

    randomized_prim_maze_generator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_random_value(i_random_value),
        .i_read_row(i_read_row), .i_read_col(i_read_col),
        .o_result_strobe(o_result_strobe),
        .o_cell_row(seen.cell_row), .o_cell_col(seen.cell_col),
        .o_wall_row(seen.wall_row), .o_wall_col(seen.wall_col),
        .o_cell_state(seen.cell_state), .o_frontier_left(seen.frontier_left),
        .o_finished(seen.finished),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the maze state
    logic [1:0]        maze_cells [GRID_SIDE*GRID_SIDE];
    logic [11:0]       frontier_cells [LIST_DEPTH];
    int unsigned       frontier_n;
    logic [SIDE_W-1:0] side_reg;

    maze_result_t expected_results [$];
    int mismatches = 0;
    int item_no = 0;
    int starts_done = 0, steps_done = 0, reads_done = 0, sides_used = 0;

    function automatic logic [1:0] cell_at(int unsigned r, int unsigned c);
        if (r >= GRID_SIDE || c >= GRID_SIDE) return CELL_WALL;
        return maze_cells[r*GRID_SIDE + c];
    endfunction

    function automatic void mark_cell(int unsigned r, int unsigned c, logic [1:0] v);
        if (r < GRID_SIDE && c < GRID_SIDE) maze_cells[r*GRID_SIDE + c] = v;
    endfunction

    function automatic void add_frontier(int unsigned r, int unsigned c);
        if (cell_at(r, c) != CELL_UNVISITED) return;
        if (frontier_n >= LIST_DEPTH) return;
        mark_cell(r, c, CELL_FRONTIER);
        frontier_cells[frontier_n] = 12'(r*GRID_SIDE + c);
        frontier_n++;
    endfunction

    // work out the result of one transaction and advance the shadow state
    function automatic maze_result_t grow_maze(t_opcode op, logic [RND_W-1:0] rnd,
                                               logic [COORD_W-1:0] rr,
                                               logic [COORD_W-1:0] rc);
        maze_result_t res;
        int unsigned s, idx, x, y;
        res = '0;
        s = side_reg;
        if (s < MIN_SIDE) s = MIN_SIDE;
        if (s > GRID_SIDE) s = GRID_SIDE;
        case (op)
            OP_START: begin
                for (int r = 0; r < GRID_SIDE; r++)
                    for (int c = 0; c < GRID_SIDE; c++)
                        mark_cell(r, c, (r[0] && c[0] && r < s-1 && c < s-1) ?
                                  CELL_UNVISITED : CELL_WALL);
                mark_cell(1, 1, CELL_OPEN);
                mark_cell(3, 1, CELL_FRONTIER);
                mark_cell(1, 3, CELL_FRONTIER);
                frontier_cells[0] = 12'(1*GRID_SIDE + 3);
                frontier_cells[1] = 12'(3*GRID_SIDE + 1);
                frontier_n = 2;
            end
            OP_STEP: begin
                if (frontier_n == 0) begin
                    res.finished = 1'b1;
                end else begin
                    idx = rnd % frontier_n;
                    x = frontier_cells[idx] / GRID_SIDE;
                    y = frontier_cells[idx] % GRID_SIDE;
                    frontier_cells[idx] = frontier_cells[frontier_n-1];
                    frontier_n--;
                    // first wall towards an open cell
                    if (x+2 < s && cell_at(x+2, y) == CELL_OPEN) begin
                        res.wall_row = COORD_W'(x+1);
                        res.wall_col = COORD_W'(y);
                        mark_cell(x+1, y, CELL_OPEN);
                    end else if (x > 2 && cell_at(x-2, y) == CELL_OPEN) begin
                        res.wall_row = COORD_W'(x-1);
                        res.wall_col = COORD_W'(y);
                        mark_cell(x-1, y, CELL_OPEN);
                    end else if (y+2 < s && cell_at(x, y+2) == CELL_OPEN) begin
                        res.wall_row = COORD_W'(x);
                        res.wall_col = COORD_W'(y+1);
                        mark_cell(x, y+1, CELL_OPEN);
                    end else if (y > 2 && cell_at(x, y-2) == CELL_OPEN) begin
                        res.wall_row = COORD_W'(x);
                        res.wall_col = COORD_W'(y-1);
                        mark_cell(x, y-1, CELL_OPEN);
                    end
                    mark_cell(x, y, CELL_OPEN);
                    if (x+2 < s) add_frontier(x+2, y);
                    if (x > 2)   add_frontier(x-2, y);
                    if (y+2 < s) add_frontier(x, y+2);
                    if (y > 2)   add_frontier(x, y-2);
                    res.cell_row = COORD_W'(x);
                    res.cell_col = COORD_W'(y);
                end
            end
            OP_READ: begin
                res.cell_row = rr;
                res.cell_col = rc;
                res.cell_state = cell_at(rr, rc);
            end
            default: ;
        endcase
        res.frontier_left = frontier_n[LEFT_W-1:0];
        return res;
    endfunction

    // issue one transaction, with an occasional gap before it
    task automatic issue(t_opcode op, logic [RND_W-1:0] rnd, logic [COORD_W-1:0] rr,
                         logic [COORD_W-1:0] rc, bit typed, maze_result_t want);
        maze_result_t pred;
        bit quiet;
        quiet = (item_no >= 400 && item_no < 700);
        if (!quiet && $urandom_range(0, 99) < 8) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_random_value <= rnd;
        i_read_row <= rr;
        i_read_col <= rc;
        do @(posedge i_clk); while (busy);
        pred = grow_maze(op, rnd, rr, rc);
        expected_results.push_back(typed ? want : pred);
        item_no++;
        case (op)
            OP_START: starts_done++;
            OP_STEP:  steps_done++;
            OP_READ:  reads_done++;
            default: ;
        endcase
    endtask

    // drain all results, then write the side register
    task automatic write_side(logic [SIDE_W-1:0] value);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        side_reg = value;
        sides_used++;
    endtask

    // check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", seen);
            end else begin
                maze_result_t w;
                w = expected_results.pop_front();
                if (seen.cell_row !== w.cell_row || seen.cell_col !== w.cell_col ||
                    seen.wall_row !== w.wall_row || seen.wall_col !== w.wall_col ||
                    seen.cell_state !== w.cell_state ||
                    seen.frontier_left !== w.frontier_left ||
                    seen.finished !== w.finished) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", w, seen);
                end
            end
        end
    end

    // directed rows, typed only where the answer is obvious
    localparam maze_result_t NONE = '0;
    stim_row_t directed [21] = '{
        '{OP_STEP,  16'h0000, 6'd0,  6'd0,  1'b1, '{0, 0, 0, 0, CELL_WALL, 0, 1}},
        '{OP_READ,  16'h0000, 6'd0,  6'd0,  1'b1, '{0, 0, 0, 0, CELL_WALL, 0, 0}},
        '{OP_READ,  16'hFFFF, 6'd63, 6'd63, 1'b1, '{63, 63, 0, 0, CELL_WALL, 0, 0}},
        '{OP_NOP,   16'hFFFF, 6'd63, 6'd63, 1'b1, '{0, 0, 0, 0, CELL_WALL, 0, 0}},
        '{OP_START, 16'h0000, 6'd0,  6'd0,  1'b1, '{0, 0, 0, 0, CELL_WALL, 2, 0}},
        '{OP_READ,  16'h0000, 6'd1,  6'd1,  1'b1, '{1, 1, 0, 0, CELL_OPEN, 2, 0}},
        '{OP_READ,  16'h0000, 6'd1,  6'd3,  1'b1, '{1, 3, 0, 0, CELL_FRONTIER, 2, 0}},
        '{OP_READ,  16'h0000, 6'd3,  6'd1,  1'b1, '{3, 1, 0, 0, CELL_FRONTIER, 2, 0}},
        '{OP_READ,  16'h0000, 6'd2,  6'd1,  1'b1, '{2, 1, 0, 0, CELL_WALL, 2, 0}},
        '{OP_NOP,   16'h0000, 6'd0,  6'd0,  1'b1, '{0, 0, 0, 0, CELL_WALL, 2, 0}},
        '{OP_STEP,  16'h0000, 6'd0,  6'd0,  1'b0, NONE},
        '{OP_STEP,  16'hFFFF, 6'd0,  6'd0,  1'b0, NONE},
        '{OP_STEP,  16'h0001, 6'd0,  6'd0,  1'b0, NONE},
        '{OP_STEP,  16'h8000, 6'd0,  6'd0,  1'b0, NONE},
        '{OP_READ,  16'h0000, 6'd1,  6'd2,  1'b0, NONE},
        '{OP_READ,  16'h0000, 6'd30, 6'd30, 1'b0, NONE},
        '{OP_READ,  16'h0000, 6'd29, 6'd29, 1'b0, NONE},
        '{OP_STEP,  16'h0007, 6'd0,  6'd0,  1'b0, NONE},
        '{OP_START, 16'hFFFF, 6'd63, 6'd63, 1'b1, '{0, 0, 0, 0, CELL_WALL, 2, 0}},
        '{OP_READ,  16'h0000, 6'd3,  6'd3,  1'b1, '{3, 3, 0, 0, CELL_UNVISITED, 2, 0}},
        '{OP_STEP,  16'h1234, 6'd0,  6'd0,  1'b0, NONE}
    };

    // main stimulus
    initial begin
        logic [SIDE_W-1:0] side_list [7];
        int phase, phase_len, pick, s;
        t_opcode op;
        logic [COORD_W-1:0] rr, rc;
        side_list = '{7'd5, 7'd64, 7'd127, 7'd0, 7'd31, 7'd6, 7'd9};
        for (int i = 0; i < GRID_SIDE*GRID_SIDE; i++) maze_cells[i] = CELL_WALL;
        frontier_n = 0;
        side_reg = 7'd31;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_opcode <= OP_NOP;
        i_random_value <= '0;
        i_read_row <= '0;
        i_read_col <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            issue(directed[k].op, directed[k].rnd, directed[k].row, directed[k].col,
                  directed[k].typed, directed[k].want);

        // random phases, each under its own side setting
        phase = 0;
        while (item_no < 1750) begin
            write_side(phase < 7 ? side_list[phase] : 7'($urandom_range(0, 127)));
            if (phase == 0 || $urandom_range(0, 3) != 0)
                issue(OP_START, 16'($urandom), 6'($urandom), 6'($urandom), 1'b0, NONE);
            phase_len = $urandom_range(150, 280);
            s = side_reg < MIN_SIDE ? MIN_SIDE : (side_reg > 64 ? 64 : side_reg);
            for (int j = 0; j < phase_len && item_no < 1750; j++) begin
                pick = $urandom_range(0, 99);
                op = pick < 2 ? OP_START : pick < 80 ? OP_STEP : pick < 95 ? OP_READ : OP_NOP;
                if ($urandom_range(0, 1)) begin
                    rr = 6'($urandom_range(0, s));
                    rc = 6'($urandom_range(0, s));
                end else begin
                    rr = 6'($urandom);
                    rc = 6'($urandom);
                end
                issue(op, 16'($urandom), rr, rc, 1'b0, NONE);
            end
            phase++;
        end
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d transactions: %0d starts, %0d steps, %0d reads, %0d side writes",
                 item_no, starts_done, steps_done, reads_done, sides_used);
        $display("mismatches counted: %0d", mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mpg_pkg.sv
src/mpg_div.sv
src/mpg_dp.sv
src/mpg_ctrl.sv
src/randomized_prim_maze_generator.sv
tb/sv/randomized_prim_maze_generator_test.sv
